// ===== design/cfs_pkg.sv =====
// Shared types, sizes and codes of the call frame stack.
package cfs_pkg;

    localparam int MAX_FRAMES  = 64;
    localparam int STACK_BYTES = 65536;

    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int IDX_W  = $clog2(MAX_FRAMES);
    localparam int TOP_W  = $clog2(STACK_BYTES + 1);
    localparam int NEED_W = ((TOP_W > 17) ? TOP_W : 17) + 1;
    localparam int ADDR_W = 32;
    localparam int CFG_W  = 32;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic REQ_CALL   = 1'b0;
    localparam logic REQ_RETURN = 1'b1;

    localparam logic REG_STACK_BASE      = 1'b0;
    localparam logic REG_KERNEL_ARG_BASE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] local_size;
        logic [15:0] param_size;
        logic [15:0] function_id;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  depth;
        logic [15:0] top_function_id;
        logic [31:0] local_addr;
        logic [31:0] param_addr;
        logic [31:0] arg_addr;
        logic        arg_from_kernel;
    } result_t;

    typedef struct packed {
        logic [15:0] loc;
        logic [15:0] par;
        logic [15:0] fid;
    } frame_t;

    localparam int FRAME_W = $bits(frame_t);

endpackage

// ===== design/cfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/call_frame_stack.sv =====
// Top level of the call frame stack: request handling, frame cache and result.
//
// Each request (call or return) is taken on any cycle with start high; busy is
// always low, so one item per clock is sustained. The result of an item appears
// on result with done high for exactly one cycle, the cycle right after the item
// is taken; the receiver cannot stall it, so it must take it on that cycle.
// The two top frames live in registers and the third one is kept ready from the
// frame RAM (one write and one registered read port), so a run of returns never
// waits for memory. The RAM needs no clearing pass: only frames that were pushed
// are ever read. Configuration writes take effect on the next cycle and must be
// made while no result is pending.
module call_frame_stack
    import cfs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             req,
    output logic             done,
    output result_t          result,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    // Stack state
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TOP_W-1:0]  top_reg, top_next;
    frame_t            tfr_reg, tfr_next;     // top frame
    frame_t            sfr_reg, sfr_next;     // frame below the top
    frame_t            byp_reg, byp_next;     // third frame, while the RAM catches up
    logic              use_byp_reg, use_byp_next;

    // Configuration
    logic [ADDR_W-1:0] stack_base_reg;
    logic [ADDR_W-1:0] karg_base_reg;

    // Result side
    logic              done_reg;
    logic [1:0]        status_reg, status_next;

    // Frame RAM
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  ram_raddr;
    logic [FRAME_W-1:0] ram_rdata;
    frame_t            third;

    logic              accept;
    logic [NEED_W-1:0] need;
    logic [NEED_W-1:0] popped;
    logic              can_push;
    logic [CNT_W-1:0]  wr_pos;
    logic [CNT_W-1:0]  rd_pos;

    assign busy   = 1'b0;
    assign accept = start;
    assign third  = use_byp_reg ? byp_reg : frame_t'(ram_rdata);

    assign need   = NEED_W'(top_reg) + NEED_W'(req.local_size) + NEED_W'(req.param_size);
    assign popped = NEED_W'(top_reg) - NEED_W'(tfr_reg.loc) - NEED_W'(tfr_reg.par);
    assign can_push = (count_reg < CNT_W'(MAX_FRAMES)) && (need <= NEED_W'(STACK_BYTES));

    // Request handling: push into the top register, spill the old second frame
    // to RAM; pop pulls the second and third frames up; a failed request only sets the status.
    always_comb
    begin
        count_next   = count_reg;
        top_next     = top_reg;
        tfr_next     = tfr_reg;
        sfr_next     = sfr_reg;
        byp_next     = byp_reg;
        use_byp_next = use_byp_reg;
        status_next  = ST_OK;
        ram_we       = 1'b0;
        if (accept)
        begin
            if (req.req_type == REQ_CALL)
            begin
                if (can_push)
                begin
                    count_next   = count_reg + CNT_W'(1);
                    top_next     = need[TOP_W-1:0];
                    tfr_next     = '{loc: req.local_size, par: req.param_size,
                                     fid: req.function_id};
                    sfr_next     = tfr_reg;
                    byp_next     = sfr_reg;
                    use_byp_next = 1'b1;
                    ram_we       = (count_reg >= CNT_W'(2));
                end
                else
                begin
                    status_next = ST_OVERFLOW;
                end
            end
            else
            begin
                if (count_reg != '0)
                begin
                    count_next   = count_reg - CNT_W'(1);
                    top_next     = popped[TOP_W-1:0];
                    tfr_next     = sfr_reg;
                    sfr_next     = third;
                    use_byp_next = 1'b0;
                end
                else
                begin
                    status_next = ST_UNDERFLOW;
                end
            end
        end
    end

    // Spill goes to the slot of the old second frame; always fetch the frame
    // that will sit third after this cycle.
    assign wr_pos    = count_reg - CNT_W'(2);
    assign rd_pos    = count_next - CNT_W'(3);
    assign ram_waddr = wr_pos[IDX_W-1:0];
    assign ram_raddr = rd_pos[IDX_W-1:0];

    cfs_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (MAX_FRAMES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sfr_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            top_reg        <= '0;
            use_byp_reg    <= 1'b0;
            done_reg       <= 1'b0;
            status_reg     <= ST_OK;
            stack_base_reg <= '0;
            karg_base_reg  <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            top_reg     <= top_next;
            use_byp_reg <= use_byp_next;
            done_reg    <= accept;
            status_reg  <= status_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STACK_BASE:      stack_base_reg <= cfg_wdata;
                    REG_KERNEL_ARG_BASE: karg_base_reg  <= cfg_wdata;
                    default:             stack_base_reg <= stack_base_reg;
                endcase
            end
        end
    end

    // Frame payload needs no reset: it is only read below the frame count.
    always_ff @(posedge clk)
    begin
        tfr_reg <= tfr_next;
        sfr_reg <= sfr_next;
        byp_reg <= byp_next;
    end

    // Result fields follow from the state left by the item just taken.
    always_comb
    begin
        logic [ADDR_W-1:0] laddr;
        laddr  = stack_base_reg + ADDR_W'(top_reg) - ADDR_W'(tfr_reg.loc)
                 - ADDR_W'(tfr_reg.par);
        result = '0;
        result.status = status_reg;
        result.depth  = 7'(count_reg);
        if (count_reg != '0)
        begin
            result.top_function_id = tfr_reg.fid;
            result.local_addr      = laddr;
            result.param_addr      = stack_base_reg + ADDR_W'(top_reg) - ADDR_W'(tfr_reg.par);
            if (count_reg == CNT_W'(1))
            begin
                result.arg_addr        = karg_base_reg;
                result.arg_from_kernel = 1'b1;
            end
            else
            begin
                result.arg_addr = laddr - ADDR_W'(sfr_reg.par);
            end
        end
    end

    assign done = done_reg;

    // Checks
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("item taken without a result on the next cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_FRAMES))
        else $error("frame count beyond capacity");

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TOP_W'(STACK_BYTES))
        else $error("stack top beyond byte capacity");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (top_reg == '0))
        else $error("bytes in use on an empty stack");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status_reg == ST_UNDERFLOW)) |-> (count_reg == '0))
        else $error("underflow reported with frames on the stack");

endmodule
